// ===== hdl/lzwe_pkg.sv =====
// shared constants, payload types and the status struct of the lzw encoder
`timescale 1ns / 1ps
package lzwe_pkg;

    localparam int CODE_BITS       = 12;
    localparam int DICT_ENTRIES    = 4096;
    localparam int HASH_BITS       = 13;
    localparam int HASH_SLOTS      = 1 << HASH_BITS;
    localparam int FIRST_FREE_CODE = 256;
    localparam int CODE_SPACE      = 1 << CODE_BITS;
    localparam int CODE_LIMIT      = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
    localparam int NFC_BITS        = CODE_BITS + 1;

    // slot generation tag, zero marks a swept slot
    localparam int EPOCH_BITS = 4;
    localparam int EPOCH_MAX  = (1 << EPOCH_BITS) - 1;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam int HASH_SHIFT = 15;

    localparam int INQ_DEPTH  = 2;
    localparam int INQ_BITS   = 1;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_BITS  = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [CODE_BITS-1:0] out_code;
        logic                 out_last;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic first;
    } t_work;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [CODE_BITS-1:0]  prefix;
        logic [7:0]            sym;
        logic [CODE_BITS-1:0]  code;
    } t_slot;

    typedef struct packed {
        logic [OUTQ_BITS:0] free;
        logic               full;
    } t_oq_stat;

endpackage

// ===== hdl/lzwe_front.sv =====
// front end: takes input beats, tags the first byte of each stream, queues work
`timescale 1ns / 1ps
module lzwe_front import lzwe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_ready,
    output logic  o_work_valid,
    output t_work o_work,
    input  logic  i_work_ready
);

    t_work               r_q [INQ_DEPTH];
    logic [INQ_BITS-1:0] r_wp;
    logic [INQ_BITS-1:0] r_rp;
    logic [INQ_BITS:0]   r_cnt;
    logic                r_fresh;
    logic                push;
    logic                pop;

    assign o_ready      = (r_cnt != (INQ_BITS+1)'(INQ_DEPTH));
    assign o_work_valid = (r_cnt != '0);
    assign o_work       = r_q[r_rp];
    assign push         = i_valid & o_ready;
    assign pop          = o_work_valid & i_work_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{item: i_data, first: r_fresh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_fresh <= 1'b1;
        end else begin
            if (push) begin
                r_wp    <= r_wp + 1'b1;
                r_fresh <= i_data.in_last;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/lzwe_back.sv =====
// back end: hash probe sequencer, dictionary store and code emission
`timescale 1ns / 1ps
module lzwe_back import lzwe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_work_valid,
    input  t_work    i_work,
    output logic     o_work_ready,
    output logic     o_push,
    output t_out     o_push_data,
    input  t_oq_stat i_oq,
    output logic     o_clearing
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CMP   = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CODE_BITS-1:0]  r_match, n_match;
    logic [NFC_BITS-1:0]   r_free, n_free;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic [HASH_BITS-1:0]  r_clr, n_clr;
    logic [HASH_BITS-1:0]  r_addr, n_addr;
    logic [HASH_BITS-1:0]  r_probe, n_probe;
    logic [31:0]           r_prod;
    logic [7:0]            r_byte;
    logic                  r_last;

    t_slot                 r_mem [HASH_SLOTS];
    t_slot                 r_rd;

    logic                  room;
    logic                  pop;
    logic                  we;
    logic [HASH_BITS-1:0]  wa;
    t_slot                 wd;
    logic [HASH_BITS-1:0]  rd_addr;
    logic                  end_stream;
    logic [31:0]           key;
    logic [31:0]           folded;
    logic                  slot_live;
    logic                  slot_hit;
    logic                  can_add;

    assign room         = (i_oq.free >= (OUTQ_BITS+1)'(2));
    assign o_work_ready = (r_state == S_IDLE) & room;
    assign pop          = o_work_ready & i_work_valid;
    assign o_clearing   = (r_state == S_CLEAR);

    assign key       = {8'd0, 16'(r_match), i_work.item.in_byte};
    assign folded    = r_prod ^ (r_prod >> HASH_SHIFT);
    assign slot_live = (r_rd.epoch == r_epoch);
    assign slot_hit  = slot_live & (r_rd.prefix == r_match) & (r_rd.sym == r_byte);
    assign can_add   = (r_free < NFC_BITS'(CODE_LIMIT));

    always_comb begin
        n_state     = r_state;
        n_match     = r_match;
        n_free      = r_free;
        n_epoch     = r_epoch;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_probe     = r_probe;
        o_push      = 1'b0;
        o_push_data = '0;
        we          = 1'b0;
        wa          = r_addr;
        wd          = '0;
        rd_addr     = r_addr + 1'b1;
        end_stream  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wa    = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                    n_epoch = EPOCH_BITS'(1);
                end
            end
            S_IDLE: begin
                if (pop) begin
                    if (i_work.first) begin
                        n_match = {{(CODE_BITS-8){1'b0}}, i_work.item.in_byte};
                        if (i_work.item.in_last) begin
                            o_push      = 1'b1;
                            o_push_data = '{out_code: {{(CODE_BITS-8){1'b0}},
                                                       i_work.item.in_byte},
                                            out_last: 1'b1};
                            end_stream  = 1'b1;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                rd_addr = folded[HASH_BITS-1:0];
                n_addr  = folded[HASH_BITS-1:0];
                n_probe = '0;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (slot_hit) begin
                    n_match = r_rd.code;
                    if (r_last) begin
                        o_push      = 1'b1;
                        o_push_data = '{out_code: r_rd.code, out_last: 1'b1};
                        end_stream  = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (slot_live && (r_probe != '1)) begin
                    // occupied by another string, step to the next slot
                    n_addr  = r_addr + 1'b1;
                    n_probe = r_probe + 1'b1;
                end else begin
                    // miss: empty slot found, or every slot probed
                    o_push      = 1'b1;
                    o_push_data = '{out_code: r_match, out_last: 1'b0};
                    if (can_add && !slot_live) begin
                        we     = 1'b1;
                        wa     = r_addr;
                        wd     = '{epoch: r_epoch, prefix: r_match, sym: r_byte,
                                   code: r_free[CODE_BITS-1:0]};
                        n_free = r_free + 1'b1;
                    end
                    n_match = {{(CODE_BITS-8){1'b0}}, r_byte};
                    n_state = r_last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                o_push      = 1'b1;
                o_push_data = '{out_code: r_match, out_last: 1'b1};
                end_stream  = 1'b1;
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
        if (end_stream) begin
            n_free = NFC_BITS'(FIRST_FREE_CODE);
            if (r_epoch == EPOCH_BITS'(EPOCH_MAX)) begin
                n_state = S_CLEAR;
                n_epoch = '0;
            end else begin
                n_state = S_IDLE;
                n_epoch = r_epoch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_byte <= i_work.item.in_byte;
            r_last <= i_work.item.in_last;
            r_prod <= 32'(key * HASH_MULT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_match <= '0;
            r_free  <= NFC_BITS'(FIRST_FREE_CODE);
            r_epoch <= '0;
            r_clr   <= '0;
            r_addr  <= '0;
            r_probe <= '0;
        end else begin
            r_state <= n_state;
            r_match <= n_match;
            r_free  <= n_free;
            r_epoch <= n_epoch;
            r_clr   <= n_clr;
            r_addr  <= n_addr;
            r_probe <= n_probe;
        end
    end

endmodule

// ===== hdl/lzwe_outq.sv =====
// output queue holding emitted codes until the consumer takes them
`timescale 1ns / 1ps
module lzwe_outq import lzwe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_out     i_push_data,
    output t_oq_stat o_stat,
    output logic     o_valid,
    output t_out     o_data,
    input  logic     i_ready
);

    t_out                 r_q [OUTQ_DEPTH];
    logic [OUTQ_BITS-1:0] r_wp;
    logic [OUTQ_BITS-1:0] r_rp;
    logic [OUTQ_BITS:0]   r_cnt;
    logic                 pop;

    assign o_valid     = (r_cnt != '0);
    assign o_data      = r_q[r_rp];
    assign pop         = o_valid & i_ready;
    assign o_stat.full = (r_cnt == (OUTQ_BITS+1)'(OUTQ_DEPTH));
    assign o_stat.free = (OUTQ_BITS+1)'(OUTQ_DEPTH) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/lzw_encoder_top.sv =====
// top level of the lzw encoder: front queue, probe sequencer, output queue
`timescale 1ns / 1ps
//
// channel   direction  beat                         handshake
// input     in         t_in  {in_byte, in_last}     i_valid / o_ready
// output    out        t_out {out_code, out_last}   o_valid / i_ready
//
// steps: the first byte of a stream is taken in the idle state alone; any other byte
//   passes issue and hash multiply, slot read and compare, with a further compare for
//   each extra probe on a collision, and a flush step when a miss on the last byte also flushes
// reset: a sweep over all HASH_SLOTS slots (8192) tags every slot empty; the same
//   sweep runs after every 15th stream when the slot generation tag wraps
// stalls: the front queue takes two beats during a sweep or probe; the back end
//   starts a byte only with room for two codes in the output queue
module lzw_encoder_top import lzwe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    // work queue between front and back
    logic     work_valid;
    logic     work_ready;
    t_work    work;

    // back end into output queue
    logic     oq_push;
    t_out     oq_push_data;
    t_oq_stat oq_stat;
    logic     clearing;

    lzwe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_ready      (o_ready),
        .o_work_valid (work_valid),
        .o_work       (work),
        .i_work_ready (work_ready)
    );

    lzwe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_ready (work_ready),
        .o_push       (oq_push),
        .o_push_data  (oq_push_data),
        .i_oq         (oq_stat),
        .o_clearing   (clearing)
    );

    lzwe_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (oq_push),
        .i_push_data (oq_push_data),
        .o_stat      (oq_stat),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_ready     (i_ready)
    );

    // the room check at byte start must keep the output queue from overflowing
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_push |-> !oq_stat.full)
        else $error("output queue push while full");

    // no byte is started while the slot store is being swept
    a_no_work_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (work_valid && work_ready) |-> !clearing)
        else $error("byte taken during slot sweep");

    // a started byte always has room for both of its codes
    a_room_for_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (work_valid && work_ready) |-> (oq_stat.free >= (OUTQ_BITS+1)'(2)))
        else $error("byte started without room for two codes");

endmodule

// ===== tb/lzw_code_checker.sv =====
// scoreboard for the lzw encoder: predicts the code stream from accepted bytes and checks it
`timescale 1ns / 1ps
module lzw_code_checker import lzwe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    localparam int REPORT_MAX = 200;

    // phrase table: {prefix code, byte} -> code
    logic [CODE_BITS-1:0] phrase_tab [bit [CODE_BITS+7:0]];
    logic [CODE_BITS-1:0] cur_code;
    logic                 have_match;
    int unsigned          free_code;
    t_out                 code_q [$];
    int unsigned          fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic void restart_stream();
        phrase_tab.delete();
        cur_code   = '0;
        have_match = 1'b0;
        free_code  = FIRST_FREE_CODE;
    endfunction

    function automatic void encode_byte(input t_in beat);
        logic [CODE_BITS+7:0] key;
        t_out                 res;
        if (!have_match) begin
            cur_code   = CODE_BITS'(beat.in_byte);
            have_match = 1'b1;
        end else begin
            key = {cur_code, beat.in_byte};
            if (phrase_tab.exists(key)) begin
                cur_code = phrase_tab[key];
            end else begin
                res.out_code = cur_code;
                res.out_last = 1'b0;
                code_q = {code_q, res};
                // no add once codes run out or every slot is taken
                if (free_code < CODE_LIMIT && phrase_tab.num() < HASH_SLOTS) begin
                    phrase_tab[key] = free_code[CODE_BITS-1:0];
                    free_code++;
                end
                cur_code = CODE_BITS'(beat.in_byte);
            end
        end
        if (beat.in_last) begin
            res.out_code = cur_code;
            res.out_last = 1'b1;
            code_q = {code_q, res};
            restart_stream();
        end
    endfunction

    task automatic report_mismatch(input string what);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
            $display("%0t ns lzw check: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            restart_stream();
            code_q.delete();
        end else begin
            // a code beat can never come from the byte accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (code_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected code beat: code %0d last %0b",
                                              i_out_data.out_code, i_out_data.out_last));
                end else begin
                    want = code_q.pop_front();
                    if (i_out_data.out_code !== want.out_code) begin
                        report_mismatch($sformatf("out_code %0d, want %0d",
                                                  i_out_data.out_code, want.out_code));
                    end
                    if (i_out_data.out_last !== want.out_last) begin
                        report_mismatch($sformatf("out_last %0b, want %0b (code %0d)",
                                                  i_out_data.out_last, want.out_last,
                                                  want.out_code));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                encode_byte(i_in_data);
            end
        end
        o_pending <= code_q.size();
    end

endmodule

// ===== tb/lzw_encoder_top_tb.sv =====
// testbench top for the lzw encoder: byte stimulus, backpressure and the verdict
`timescale 1ns / 1ps
module lzw_encoder_top_tb;
    import lzwe_pkg::*;

    // kinds of byte content for a stream
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_REPEAT
    } t_fill;

    localparam int RANDOM_BEATS = 480;
    localparam int TOTAL_BEATS  = 600;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 40;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    t_in         in_data;
    logic        in_ready;
    logic        out_valid;
    t_out        out_data;
    logic        out_ready;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned beats_sent = 0;
    int unsigned calm_beats = 0;
    logic        quiet = 1'b0;     // final part of the run: no idling on either side

    // 50 MHz clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lzw_encoder_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .i_data  (in_data),
        .o_ready (in_ready),
        .o_valid (out_valid),
        .o_data  (out_data),
        .i_ready (out_ready)
    );

    lzw_code_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // one byte beat; entered and left at a falling edge, valid left high on exit
    task automatic send_beat(input logic [7:0] b, input logic lst);
        int unsigned gap;
        gap = 0;
        if (!quiet) begin
            // calm stretches keep the block busy back to back for a while
            if (calm_beats > 0) begin
                calm_beats--;
            end else if ($urandom_range(0, 39) == 0) begin
                calm_beats = $urandom_range(20, 80);
            end else if ($urandom_range(0, 9) < 2) begin
                gap = $urandom_range(1, 11);
            end
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_last: lst};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        beats_sent++;
    endtask

    // a run of bytes; close marks the final one as the end of the stream
    task automatic send_stream(input int unsigned len, input t_fill fill, input logic close);
        logic [7:0]  pat [4];
        logic [7:0]  b;
        int unsigned period;
        int unsigned n;
        period = $urandom_range(1, 4);
        foreach (pat[k]) pat[k] = 8'($urandom);
        for (n = 0; n < len; n++) begin
            case (fill)
                FILL_NARROW: begin
                    b = pat[2'($urandom_range(0, period - 1))];
                end
                FILL_REPEAT: begin
                    b = pat[2'(n % period)];
                end
                default: begin
                    b = 8'($urandom);
                end
            endcase
            send_beat(b, close && (n == len - 1));
        end
    endtask

    // sink side: ready drops low in random bursts, with calm stretches between
    initial begin
        int unsigned hold;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (quiet) begin
                out_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 8) begin
                hold = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
                out_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 2) begin
                hold = $urandom_range(30, 150);
                out_ready <= 1'b1;
                repeat (hold) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // run limit: reset sweep, every 15th stream's sweep, worst stalls, several times over
    initial begin
        #20ms;
        $display("lzw_encoder_top regression: fail");
        $finish;
    end

    initial begin
        int unsigned len;
        int unsigned waited;
        t_fill       fill;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: a one-byte stream, flushed with nothing before it
        send_beat(8'h00, 1'b1);
        // run of one byte: hits on the new string, the last byte misses and flushes, three codes
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
        // last byte hits, so only the flushed match comes out
        send_beat(8'h78, 1'b0);
        send_beat(8'h79, 1'b0);
        send_beat(8'h78, 1'b0);
        send_beat(8'h79, 1'b1);
        // alternating bit patterns, each byte bit both ways
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b1);
        // fresh bytes, a miss on every step
        send_beat(8'h00, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFE, 1'b0);
        send_beat(8'h7F, 1'b1);
        // stream restarts clean after the flush
        send_beat(8'hFF, 1'b1);

        // random streams, mostly short ones so the tag wrap sweep comes round more than once
        while (beats_sent < RANDOM_BEATS) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
            fill = t_fill'($urandom_range(0, 2));
            send_stream(len, fill, 1'b1);
        end

        // closing part without idling
        quiet = 1'b1;
        while (beats_sent < TOTAL_BEATS) begin
            send_stream($urandom_range(1, 20), t_fill'($urandom_range(0, 2)), 1'b1);
        end
        in_valid <= 1'b0;

        // drain what is still owed, then give stray beats time to show up
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("lzw_encoder_top regression: pass");
        end else begin
            $display("lzw_encoder_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lzwe_pkg.sv
hdl/lzwe_front.sv
hdl/lzwe_back.sv
hdl/lzwe_outq.sv
hdl/lzw_encoder_top.sv
tb/lzw_code_checker.sv
tb/lzw_encoder_top_tb.sv
